// ===== rtl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types, constants and helpers for the case-insensitive substring
// matcher: needle geometry, register map, configuration bundle, ASCII fold.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

  // Needle and position geometry
  localparam int NeedleMaxBytes = 16;
  localparam int LenBits        = $clog2(NeedleMaxBytes + 1);
  localparam int IdxBits        = $clog2(NeedleMaxBytes);
  localparam int PosBits        = 16;
  localparam int CharBits       = 8;

  // Configuration port geometry
  localparam int CfgDataBits    = 64;
  localparam int CfgAddrBits    = 5;
  localparam int LenRegBits     = 5;
  localparam int NeedleRegBytes = CfgDataBits / CharBits;

  typedef logic [CharBits-1:0] char_t;

  // String terminator
  localparam char_t Terminator = '0;

  // Register index (byte address / 8)
  typedef enum logic [1:0] {
    RegNeedleLow  = 2'd0,
    RegNeedleHigh = 2'd1,
    RegNeedleLen  = 2'd2
  } cfg_reg_e;

  // Needle as seen by the cell row: byte for cell k is needle[len-1-k]
  typedef struct packed {
    logic [NeedleMaxBytes-1:0]  active;
    char_t [NeedleMaxBytes-1:0] aligned;
    logic [LenBits-1:0]         len;
  } csm_cfg_t;

  // Fold A-Z to a-z, other codes unchanged
  function automatic char_t fold_char(input char_t c);
    char_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage : csm_pkg

`default_nettype wire

// ===== rtl/case_insensitive_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// case_insensitive_substring_matcher
// Scans a zero-terminated byte stream for the first case-insensitive
// occurrence of a configured needle of up to 16 bytes, using a row of
// window cells that each compare one position in parallel.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | haystack_byte_i
//   out     | output    | out_valid_o/out_ready_i | found_o, match_position_o,
//           |           |                         | position_overflow_o
//   cfg     | input     | APB psel/penable/pready | needle low/high (64b), length
//
// One item per clock while in_ready_o is high: the cell row shifts and
// compares in the accept cycle, and the result lands in the output register
// in the cycle after acceptance. in_ready_o drops only while a result sits
// in the output register and out_ready_i is low. Reset clears the window,
// offset and flags; the registers reset to an empty needle.
// ----------------------------------------------------------------------------
`default_nettype none

module case_insensitive_substring_matcher (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // haystack items
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [7:0]                      haystack_byte_i,
  // results
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            found_o,
  output logic [csm_pkg::PosBits-1:0]     match_position_o,
  output logic                            position_overflow_o,
  // configuration
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [csm_pkg::CfgAddrBits-1:0] paddr,
  input  wire  [csm_pkg::CfgDataBits-1:0] pwdata,
  output logic [csm_pkg::CfgDataBits-1:0] prdata,
  output logic                            pready
);
  import csm_pkg::*;

  localparam logic [PosBits-1:0] OffsetMax = '1;

  csm_cfg_t cfg;

  csm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake
  logic accept;
  logic is_term;
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_term    = (haystack_byte_i == Terminator);

  // Cell row: cell 0 takes the folded input, cell k takes cell k-1
  char_t [NeedleMaxBytes-1:0] cell_in;
  char_t [NeedleMaxBytes-1:0] cell_q;
  logic  [NeedleMaxBytes-1:0] cell_ok;

  for (genvar k = 0; k < NeedleMaxBytes; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = fold_char(haystack_byte_i);
    end else begin : g_link
      assign cell_in[k] = cell_q[k-1];
    end

    csm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept && !is_term),
      .clear_i  (accept && is_term),
      .char_i   (cell_in[k]),
      .expect_i (cfg.aligned[k]),
      .active_i (cfg.active[k]),
      .char_o   (cell_q[k]),
      .match_o  (cell_ok[k])
    );
  end

  // Per-string state
  logic [PosBits-1:0] offset_q, offset_d;
  logic               sat_q, sat_d;
  logic               reported_q, reported_d;

  // Result decision
  logic               emit;
  logic               emit_found;
  logic [PosBits-1:0] emit_pos;
  logic               emit_ovf;
  logic               window_full;

  always_comb begin
    offset_d   = offset_q;
    sat_d      = sat_q;
    reported_d = reported_q;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_pos   = '0;
    emit_ovf   = sat_q;
    window_full = 1'b0;

    if (accept) begin
      if (is_term) begin
        // end of string: report a miss (or empty needle) unless already done
        emit       = !reported_q;
        emit_found = (cfg.len == '0);
        offset_d   = '0;
        sat_d      = 1'b0;
        reported_d = 1'b0;
      end else begin
        if (offset_q == OffsetMax) begin
          sat_d = 1'b1;
        end else begin
          offset_d = offset_q + PosBits'(1);
        end
        emit_ovf    = sat_d;
        window_full = sat_d || (offset_d >= PosBits'(cfg.len));
        if (!reported_q) begin
          if (cfg.len == '0) begin
            emit       = 1'b1;
            emit_found = 1'b1;
            reported_d = 1'b1;
          end else if (window_full && (&cell_ok)) begin
            emit       = 1'b1;
            emit_found = 1'b1;
            emit_pos   = sat_d ? OffsetMax : (offset_d - PosBits'(cfg.len));
            reported_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      sat_q      <= 1'b0;
      reported_q <= 1'b0;
    end else begin
      offset_q   <= offset_d;
      sat_q      <= sat_d;
      reported_q <= reported_d;
    end
  end

  // Output register
  logic               out_valid_q;
  logic               found_q;
  logic [PosBits-1:0] pos_q;
  logic               ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q <= emit_found;
      pos_q   <= emit_pos;
      ovf_q   <= emit_ovf;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign found_o             = found_q;
  assign match_position_o    = pos_q;
  assign position_overflow_o = ovf_q;

endmodule : case_insensitive_substring_matcher

`default_nettype wire

// ===== rtl/csm_cell.sv =====
// ----------------------------------------------------------------------------
// csm_cell
// One window position: holds a folded haystack character, hands it to the
// next cell on each shift, and compares the incoming character with the
// needle byte aligned to this position.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 shift_i,
  input  wire                 clear_i,
  input  wire csm_pkg::char_t char_i,
  input  wire csm_pkg::char_t expect_i,
  input  wire                 active_i,
  output csm_pkg::char_t      char_o,
  output logic                match_o
);
  import csm_pkg::*;

  char_t char_q;

  // Compare the value this cell is about to take
  assign match_o = !active_i || (char_i == expect_i);
  assign char_o  = char_q;

  // Window storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else if (clear_i) begin
      char_q <= '0;
    end else if (shift_i) begin
      char_q <= char_i;
    end
  end

endmodule : csm_cell

`default_nettype wire

// ===== rtl/csm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// csm_cfg_regs
// APB register file for the needle and its length, plus the folded and
// position-aligned needle that the cell row compares against.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_cfg_regs (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [csm_pkg::CfgAddrBits-1:0]      paddr,
  input  wire  [csm_pkg::CfgDataBits-1:0]      pwdata,
  output logic [csm_pkg::CfgDataBits-1:0]      prdata,
  output logic                                 pready,
  output csm_pkg::csm_cfg_t                    cfg_o
);
  import csm_pkg::*;

  logic [CfgDataBits-1:0] needle_low_q;
  logic [CfgDataBits-1:0] needle_high_q;
  logic [LenRegBits-1:0]  needle_len_q;

  cfg_reg_e reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_e'(paddr[CfgAddrBits-1 -: 2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_low_q  <= '0;
      needle_high_q <= '0;
      needle_len_q  <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        RegNeedleLow:  needle_low_q  <= pwdata;
        RegNeedleHigh: needle_high_q <= pwdata;
        RegNeedleLen:  needle_len_q  <= pwdata[LenRegBits-1:0];
        default:       ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_sel)
      RegNeedleLow:  prdata = needle_low_q;
      RegNeedleHigh: prdata = needle_high_q;
      RegNeedleLen:  prdata = {{(CfgDataBits-LenRegBits){1'b0}}, needle_len_q};
      default:       prdata = '0;
    endcase
  end

  // Folded needle, clamped length, per-cell alignment
  char_t [NeedleMaxBytes-1:0] folded;
  logic  [LenBits-1:0]        len;
  logic  [2*CfgDataBits-1:0]  needle_all;

  assign needle_all = {needle_high_q, needle_low_q};

  always_comb begin
    for (int i = 0; i < NeedleMaxBytes; i++) begin
      if (i < 2 * NeedleRegBytes) begin
        folded[i] = fold_char(needle_all[CharBits*i +: CharBits]);
      end else begin
        folded[i] = '0;
      end
    end
  end

  always_comb begin
    if (needle_len_q > LenRegBits'(NeedleMaxBytes)) begin
      len = LenBits'(NeedleMaxBytes);
    end else begin
      len = LenBits'(needle_len_q);
    end
  end

  always_comb begin
    logic [LenBits-1:0] idx;
    cfg_o.len = len;
    for (int k = 0; k < NeedleMaxBytes; k++) begin
      idx = len - LenBits'(k) - LenBits'(1);
      cfg_o.active[k] = (LenBits'(k) < len);
      cfg_o.aligned[k] = cfg_o.active[k] ? folded[idx[IdxBits-1:0]] : '0;
    end
  end

endmodule : csm_cfg_regs

`default_nettype wire

// ===== rtl/csm_checker.sv =====
// ----------------------------------------------------------------------------
// csm_checker
// Port-level checks on the matcher: output holding, stall cause, result
// field consistency and reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_ready_o,
  input wire                         out_valid_o,
  input wire                         out_ready_i,
  input wire                         found_o,
  input wire [csm_pkg::PosBits-1:0]  match_position_o,
  input wire                         position_overflow_o
);
  import csm_pkg::*;

  // A stalled result holds its position and found flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_position_o)
      && $stable(found_o))
    else $error("result changed while stalled");

  // Input stalls only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

  // A miss reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_position_o == '0)
    else $error("miss with nonzero position");

  // A nonzero match position after saturation is the saturated position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o && position_overflow_o && match_position_o != '0
      |-> match_position_o == '1)
    else $error("saturated match with partial position");

  // No result right out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule : csm_checker

bind case_insensitive_substring_matcher csm_checker u_csm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .found_o             (found_o),
  .match_position_o    (match_position_o),
  .position_overflow_o (position_overflow_o)
);

`default_nettype wire
